@@ hw/rtl/bts_pkg.sv @@
package bts_pkg;

	// payload widths fixed by the interface
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 4;
	localparam int STAT_W = 2;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_MEMBER    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_MINIMUM   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_MAXIMUM   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_EQUAL     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_INTERSECT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SIZE      = 4'd7;
	localparam logic [MODE_W-1:0] MODE_EMPTY     = 4'd8;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN    = 6'b000010,
		S_OUT_RD  = 6'b000100,
		S_IN_SCAN = 6'b001000,
		S_PUSH    = 6'b010000,
		S_FIN     = 6'b100000
	} bts_state_t;

endpackage

@@ hw/rtl/bounded_two_set_engine.sv @@
// Two bounded sets of signed 32-bit values, each held in its own synchronous
// memory of SET_DEPTH entries with a fill count. One request is worked on at
// a time. Insert, remove, size and empty finish in the cycle the request is
// taken. Membership, minimum and maximum walk the stored entries through the
// memory read port, one entry a cycle (membership walks the larger of the two
// counts). Equality and intersection walk the first set and, for each of its
// entries, the second set until a match; intersection hands out its results
// while walking, the final one marked. The memories have no clearing pass:
// only entries below a count are ever read.
module bounded_two_set_engine
	import bts_pkg::*;
#(
	parameter int SET_DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [MODE_W-1:0]        mode,
	input  logic                     set_select,
	input  logic signed [VAL_W-1:0]  item_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [VAL_W-1:0]  result_value,
	output logic                     in_first_set,
	output logic                     in_second_set,
	output logic                     answer_flag,
	output logic [CNT_W-1:0]         element_count,
	output logic [STAT_W-1:0]        status,
	output logic                     last_result
);

	localparam int AW = $clog2(SET_DEPTH);
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

	// set memories
	logic signed [VAL_W-1:0] mem_a [SET_DEPTH];
	logic signed [VAL_W-1:0] mem_b [SET_DEPTH];
	logic signed [VAL_W-1:0] rd_a_s1;
	logic signed [VAL_W-1:0] rd_b_s1;
	logic [AW-1:0]           addr_a;
	logic [AW-1:0]           addr_b;

	// control state
	bts_state_t     st_q;
	logic [CW-1:0]  cnt0_q;
	logic [CW-1:0]  cnt1_q;
	logic [CW-1:0]  i_q;
	logic [CW-1:0]  j_q;
	logic [CW-1:0]  lim_q;
	logic           iss_s1;
	logic           inr0_s1;
	logic           inr1_s1;
	logic           first_q;
	logic           hit0_q;
	logic           hit1_q;
	logic           eq_q;
	logic           pend_vld_q;

	// request and working payload
	logic [MODE_W-1:0]       mode_q;
	logic                    sel_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] best_q;
	logic signed [VAL_W-1:0] pend_val_q;

	// output register
	logic                    out_vld_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_m1_q;
	logic                    out_m2_q;
	logic                    out_flag_q;
	logic [CW-1:0]           out_cnt_q;
	logic [STAT_W-1:0]       out_stat_q;
	logic                    out_last_q;

	// helpers
	logic                    out_free;
	logic                    acc;
	logic [CW-1:0]           cnt_in;
	logic [CW-1:0]           cnt_op;
	logic                    full_in;
	logic signed [VAL_W-1:0] rd_sel;
	logic                    better;
	logic                    in_match;
	logic                    in_done;
	logic                    push;
	logic signed [VAL_W-1:0] r_val;
	logic                    r_m1;
	logic                    r_m2;
	logic                    r_flag;
	logic [CW-1:0]           r_cnt;
	logic [STAT_W-1:0]       r_stat;
	logic                    r_last;

	// handshake
	assign out_free   = !out_vld_q || !result_stall;
	assign item_stall = (st_q != S_IDLE) || !out_free;
	assign acc        = item_valid && !item_stall;

	assign cnt_in  = set_select ? cnt1_q : cnt0_q;
	assign cnt_op  = sel_q ? cnt1_q : cnt0_q;
	assign full_in = (cnt_in >= DEPTH_C);

	// scan compare terms
	assign rd_sel   = sel_q ? rd_b_s1 : rd_a_s1;
	assign better   = (mode_q == MODE_MINIMUM) ? (rd_sel < best_q) : (rd_sel > best_q);
	assign in_match = iss_s1 && (rd_b_s1 == rd_a_s1);
	assign in_done  = (j_q >= cnt1_q) && !iss_s1;

	// read addresses: first set holds the outer entry while the second is walked
	assign addr_a = (st_q == S_SCAN) ? j_q[AW-1:0] : i_q[AW-1:0];
	assign addr_b = j_q[AW-1:0];

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (acc && (mode == MODE_INSERT) && !full_in) begin
			if (set_select) begin
				mem_b[cnt_in[AW-1:0]] <= item_value;
			end else begin
				mem_a[cnt_in[AW-1:0]] <= item_value;
			end
		end
		rd_a_s1 <= mem_a[addr_a];
		rd_b_s1 <= mem_b[addr_b];
	end

	// result building
	always_comb begin
		push   = 1'b0;
		r_val  = '0;
		r_m1   = 1'b0;
		r_m2   = 1'b0;
		r_flag = 1'b0;
		r_cnt  = cnt_op;
		r_stat = ST_OK;
		r_last = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				r_cnt = cnt_in;
				if (acc) begin
					unique case (mode) inside
						MODE_INSERT: begin
							push = 1'b1;
							if (full_in) begin
								r_stat = ST_FULL;
							end else begin
								r_cnt = CW'(cnt_in + 1'b1);
							end
						end
						MODE_REMOVE: begin
							push = 1'b1;
							if (cnt_in == '0) begin
								r_stat = ST_EMPTY;
							end else begin
								r_cnt = CW'(cnt_in - 1'b1);
							end
						end
						MODE_MINIMUM, MODE_MAXIMUM: begin
							if (cnt_in == '0) begin
								push   = 1'b1;
								r_stat = ST_EMPTY;
							end
						end
						MODE_EQUAL: begin
							if (cnt0_q != cnt1_q) begin
								push = 1'b1;
							end
						end
						MODE_SIZE: begin
							push = 1'b1;
						end
						MODE_EMPTY: begin
							push   = 1'b1;
							r_flag = (cnt_in == '0);
						end
						default: begin
						end
					endcase
				end
			end
			S_PUSH: begin
				push  = out_free;
				r_val = pend_val_q;
			end
			S_FIN: begin
				push = out_free;
				unique case (mode_q) inside
					MODE_MEMBER: begin
						r_m1 = hit0_q;
						r_m2 = hit1_q;
					end
					MODE_MINIMUM, MODE_MAXIMUM: begin
						r_val = best_q;
					end
					MODE_EQUAL: begin
						r_flag = eq_q;
					end
					MODE_INTERSECT: begin
						r_last = 1'b1;
						if (pend_vld_q) begin
							r_val = pend_val_q;
						end else begin
							r_stat = ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			out_vld_q  <= 1'b0;
			cnt0_q     <= '0;
			cnt1_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			iss_s1     <= 1'b0;
			inr0_s1    <= 1'b0;
			inr1_s1    <= 1'b0;
			first_q    <= 1'b0;
			hit0_q     <= 1'b0;
			hit1_q     <= 1'b0;
			eq_q       <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			out_vld_q <= push || (out_vld_q && result_stall);
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						unique case (mode) inside
							MODE_INSERT: begin
								if (!full_in) begin
									if (set_select) begin
										cnt1_q <= CW'(cnt1_q + 1'b1);
									end else begin
										cnt0_q <= CW'(cnt0_q + 1'b1);
									end
								end
							end
							MODE_REMOVE: begin
								if (cnt_in != '0) begin
									if (set_select) begin
										cnt1_q <= CW'(cnt1_q - 1'b1);
									end else begin
										cnt0_q <= CW'(cnt0_q - 1'b1);
									end
								end
							end
							MODE_MEMBER: begin
								j_q    <= '0;
								iss_s1 <= 1'b0;
								hit0_q <= 1'b0;
								hit1_q <= 1'b0;
								st_q   <= S_SCAN;
							end
							MODE_MINIMUM, MODE_MAXIMUM: begin
								if (cnt_in != '0) begin
									j_q     <= '0;
									iss_s1  <= 1'b0;
									first_q <= 1'b1;
									st_q    <= S_SCAN;
								end
							end
							MODE_EQUAL: begin
								if (cnt0_q == cnt1_q) begin
									i_q  <= '0;
									eq_q <= 1'b1;
									st_q <= S_OUT_RD;
								end
							end
							MODE_INTERSECT: begin
								i_q        <= '0;
								pend_vld_q <= 1'b0;
								st_q       <= S_OUT_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// one entry read a cycle, compared in the cycle after its read
					iss_s1  <= (j_q < lim_q);
					inr0_s1 <= (j_q < cnt0_q);
					inr1_s1 <= (j_q < cnt1_q);
					if (j_q < lim_q) begin
						j_q <= CW'(j_q + 1'b1);
					end
					if (iss_s1) begin
						first_q <= 1'b0;
						if (inr0_s1 && (rd_a_s1 == val_q)) begin
							hit0_q <= 1'b1;
						end
						if (inr1_s1 && (rd_b_s1 == val_q)) begin
							hit1_q <= 1'b1;
						end
					end
					if ((j_q >= lim_q) && !iss_s1) begin
						st_q <= S_FIN;
					end
				end
				S_OUT_RD: begin
					// outer entry of the first set is being read
					j_q    <= '0;
					iss_s1 <= 1'b0;
					if (i_q >= cnt0_q) begin
						st_q <= S_FIN;
					end else begin
						st_q <= S_IN_SCAN;
					end
				end
				S_IN_SCAN: begin
					// walk the second set until the outer entry is found
					iss_s1 <= (j_q < cnt1_q);
					if (j_q < cnt1_q) begin
						j_q <= CW'(j_q + 1'b1);
					end
					if (in_match) begin
						if (mode_q == MODE_EQUAL) begin
							i_q  <= CW'(i_q + 1'b1);
							st_q <= S_OUT_RD;
						end else if (pend_vld_q) begin
							st_q <= S_PUSH;
						end else begin
							pend_vld_q <= 1'b1;
							i_q        <= CW'(i_q + 1'b1);
							st_q       <= S_OUT_RD;
						end
					end else if (in_done) begin
						if (mode_q == MODE_EQUAL) begin
							eq_q <= 1'b0;
							st_q <= S_FIN;
						end else begin
							i_q  <= CW'(i_q + 1'b1);
							st_q <= S_OUT_RD;
						end
					end
				end
				S_PUSH: begin
					if (out_free) begin
						i_q  <= CW'(i_q + 1'b1);
						st_q <= S_OUT_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields, running extreme and held intersection element
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= mode;
			sel_q  <= set_select;
			val_q  <= item_value;
			lim_q  <= (mode == MODE_MEMBER) ? ((cnt0_q > cnt1_q) ? cnt0_q : cnt1_q) : cnt_in;
		end
		if ((st_q == S_SCAN) && iss_s1 && (first_q || better)) begin
			best_q <= rd_sel;
		end
		if ((st_q == S_IN_SCAN) && in_match && !pend_vld_q) begin
			pend_val_q <= rd_a_s1;
		end
		if ((st_q == S_PUSH) && out_free) begin
			pend_val_q <= rd_a_s1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (push) begin
			out_val_q  <= r_val;
			out_m1_q   <= r_m1;
			out_m2_q   <= r_m2;
			out_flag_q <= r_flag;
			out_cnt_q  <= r_cnt;
			out_stat_q <= r_stat;
			out_last_q <= r_last;
		end
	end

	assign result_valid  = out_vld_q;
	assign result_value  = out_val_q;
	assign in_first_set  = out_m1_q;
	assign in_second_set = out_m2_q;
	assign answer_flag   = out_flag_q;
	assign element_count = CNT_W'(out_cnt_q);
	assign status        = out_stat_q;
	assign last_result   = out_last_q;

`ifndef SYNTH
	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && result_stall) |-> !push)
		else $error("result overwritten while stalled");

	// counts stay within the set depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt0_q <= DEPTH_C) && (cnt1_q <= DEPTH_C))
		else $error("set count beyond depth");

	// an insert into a first set with room grows its count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (mode == MODE_INSERT) && !set_select && (cnt0_q < DEPTH_C))
		|=> (cnt0_q == CW'($past(cnt0_q) + 1'b1)))
		else $error("insert did not grow the first set");
`endif

endmodule
